// File: hw/rtl/aocf_pkg.sv
// Shared constants, types and helper functions for the affine orbit canonical form block.
`default_nettype none

package aocf_pkg;

	localparam int NPOS   = 20;
	localparam int DW     = 2 * NPOS;
	localparam int NUNITS = 8;
	localparam int NCAND  = NUNITS * NPOS;
	localparam int KEY_W  = NPOS + DW;
	// Pairwise reduction levels needed to bring NCAND candidates down to one.
	localparam int NLVL   = 8;
	localparam int NSTG   = NLVL + 1;

	typedef logic [DW-1:0]    digits_t;
	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic            in_load;
		logic [NLVL-1:0] lvl_load;
	} pipe_ctl_t;

	localparam int UNITS [NUNITS] = '{1, 3, 7, 9, 11, 13, 17, 19};

	// Number of nodes at a reduction level; level 0 is the full candidate set.
	function automatic int lvl_n(input int lvl);
		int n;
		n = NCAND;
		for (int i = 0; i < lvl; i++) begin
			n = (n + 1) >> 1;
		end
		return n;
	endfunction

	// Offset of a level (1 and up) inside the flat node array.
	function automatic int lvl_off(input int lvl);
		int off;
		off = 0;
		for (int i = 1; i < lvl; i++) begin
			off = off + lvl_n(i);
		end
		return off;
	endfunction

	// Places digit r of src at position (u*r + s) mod NPOS.
	function automatic digits_t affine_map(input digits_t src, input int u, input int s);
		digits_t res;
		int pos;
		res = '0;
		pos = s;
		for (int r = 0; r < NPOS; r++) begin
			res[2*pos +: 2] = src[2*r +: 2];
			pos = pos + u;
			if (pos >= NPOS) begin
				pos = pos - NPOS;
			end
		end
		return res;
	endfunction

	// Support bits above digit values, position 0 most significant in both.
	function automatic key_t order_key(input digits_t d);
		key_t k;
		k = '0;
		for (int p = 0; p < NPOS; p++) begin
			k[KEY_W-1-p]      = |d[2*p +: 2];
			k[DW-2-2*p +: 2]  = d[2*p +: 2];
		end
		return k;
	endfunction

	function automatic digits_t pick_min(input digits_t a, input digits_t b);
		return (order_key(b) < order_key(a)) ? b : a;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/aocf_orbit.sv
// Input register and generation of all 160 affine images of the input word.
`default_nettype none

module aocf_orbit
	import aocf_pkg::*;
(
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire digits_t   occupancy,
	output digits_t        cand [NCAND]
);

	digits_t occupancy_s1;

	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			occupancy_s1 <= occupancy;
		end
	end

	// Each image is a fixed permutation of digit slots, so this is wiring only.
	for (genvar k = 0; k < NUNITS; k++) begin : g_unit
		for (genvar s = 0; s < NPOS; s++) begin : g_shift
			assign cand[k*NPOS + s] = affine_map(occupancy_s1, UNITS[k], s);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/aocf_min_tree.sv
// Registered pairwise minimum tree that picks the least candidate.
`default_nettype none

module aocf_min_tree
	import aocf_pkg::*;
(
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire digits_t   cand [NCAND],
	output digits_t        best
);

	localparam int NNODES = lvl_off(NLVL + 1);

	digits_t node [NNODES];

	for (genvar l = 1; l <= NLVL; l++) begin : g_lvl
		for (genvar j = 0; j < lvl_n(l); j++) begin : g_node
			digits_t a;
			digits_t b;
			digits_t tree_q;

			if (l == 1) begin : g_from_cand
				assign a = cand[2*j];
				if (2*j + 1 < lvl_n(l-1)) begin : g_pair
					assign b = cand[2*j + 1];
				end else begin : g_odd
					assign b = cand[2*j];
				end
			end else begin : g_from_node
				assign a = node[lvl_off(l-1) + 2*j];
				if (2*j + 1 < lvl_n(l-1)) begin : g_pair
					assign b = node[lvl_off(l-1) + 2*j + 1];
				end else begin : g_odd
					// An odd node out passes through to the next level unchanged.
					assign b = node[lvl_off(l-1) + 2*j];
				end
			end

			always_ff @(posedge clk) begin
				if (ctl.lvl_load[l-1]) begin
					tree_q <= pick_min(a, b);
				end
			end

			assign node[lvl_off(l) + j] = tree_q;
		end
	end

	assign best = node[NNODES-1];

endmodule

`default_nettype wire

// File: hw/rtl/affine_orbit_canonical_form_top.sv
// Throughput: one word per cycle while the output is not stalled; the input register
// and eight min-tree levels form a 9-stage pipeline in which every stage can take a
// new word each cycle.
// A stalled output lets bubbles in earlier stages close up before the input stalls.
// Reset clears only the stage valid bits; the data registers are not reset.
`default_nettype none

module affine_orbit_canonical_form_top
	import aocf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire digits_t occupancy,
	output logic         out_valid,
	input  wire logic    out_ready,
	output digits_t      canonical_occupancy
);

	logic [NSTG-1:0] valid_q;
	logic [NSTG:0]   rdy;
	pipe_ctl_t       ctl;
	digits_t         cand [NCAND];

	// A stage can load when it is empty or its word moves on this cycle.
	always_comb begin
		rdy[NSTG] = out_ready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !valid_q[i] || rdy[i+1];
		end
	end

	assign ctl.in_load  = rdy[0] && in_valid;
	assign ctl.lvl_load = rdy[NSTG-1:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (rdy[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_q[NSTG-1];

	aocf_orbit u_orbit (
		.clk       (clk),
		.ctl       (ctl),
		.occupancy (occupancy),
		.cand      (cand)
	);

	aocf_min_tree u_min_tree (
		.clk  (clk),
		.ctl  (ctl),
		.cand (cand),
		.best (canonical_occupancy)
	);

endmodule

`default_nettype wire
